// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_IMPLY_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== src/i8gemv_pkg.sv =====
// Types and constants of the int8 four-row interleaved matrix-vector unit.
package i8gemv_pkg;

    localparam int LANES           = 4;
    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int MAX_PACKS_DEF   = 1024;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int VL_W       = 13;
    localparam int PC_W       = 11;
    localparam int VEC_IDX_W  = 12;
    localparam int PACK_IDX_W = 10;

    localparam int VL_RESET = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACK_COUNT    = 1'd1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [VEC_IDX_W-1:0]   vec_index;
        logic signed [7:0]      vec_value;
        logic signed [7:0]      a_row0;
        logic signed [7:0]      a_row1;
        logic signed [7:0]      a_row2;
        logic signed [7:0]      a_row3;
    } t_in;

    typedef struct packed {
        logic signed [31:0]     sum_row0;
        logic signed [31:0]     sum_row1;
        logic signed [31:0]     sum_row2;
        logic signed [31:0]     sum_row3;
        logic [PACK_IDX_W-1:0]  pack_index;
        logic                   last_pack;
    } t_out;

    // Control that travels with a matrix item down the pipeline.
    typedef struct packed {
        logic                   valid;
        logic                   last_col;
        logic [PACK_IDX_W-1:0]  pack_index;
        logic                   last_pack;
    } t_ctl;

endpackage

// ===== src/i8gemv_vstore.sv =====
// Vector element store: one write and one read per cycle, registered read data.
module i8gemv_vstore #(
    parameter int DEPTH = i8gemv_pkg::MAX_COLUMNS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [7:0]   i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [7:0]   o_rdata
);

    logic signed [7:0] r_mem [DEPTH];
    logic signed [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/i8gemv_mac.sv =====
// Four-lane multiply, accumulate and result register with stall handling.
`include "assert_macros.svh"

module i8gemv_mac (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clr,
    input  i8gemv_pkg::t_ctl        i_ctl,
    input  logic signed [7:0]       i_a [i8gemv_pkg::LANES],
    input  logic signed [7:0]       i_b,
    input  logic                    i_stall,
    output logic                    o_adv,
    output logic                    o_valid,
    output i8gemv_pkg::t_out        o_data
);

    localparam int L = i8gemv_pkg::LANES;

    i8gemv_pkg::t_ctl   r_ctl2;
    logic signed [15:0] r_prod [L];
    logic signed [31:0] r_acc  [L];
    logic signed [31:0] w_sum  [L];
    logic               r_out_valid;
    i8gemv_pkg::t_out   r_out;
    i8gemv_pkg::t_out   n_out;
    logic               w_fire;
    logic               w_emit;

    // Only an item that must land in a full, stalled result register holds the pipe.
    assign o_adv  = !(r_ctl2.valid && r_ctl2.last_col && r_out_valid && i_stall);
    assign w_fire = o_adv && r_ctl2.valid;
    assign w_emit = w_fire && r_ctl2.last_col;

    always_comb begin
        for (int l = 0; l < L; l++) begin
            w_sum[l] = r_acc[l] + {{16{r_prod[l][15]}}, r_prod[l]};
        end
        n_out.sum_row0   = w_sum[0];
        n_out.sum_row1   = w_sum[1];
        n_out.sum_row2   = w_sum[2];
        n_out.sum_row3   = w_sum[3];
        n_out.pack_index = r_ctl2.pack_index;
        n_out.last_pack  = r_ctl2.last_pack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2      <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < L; l++) begin
                r_acc[l] <= '0;
            end
        end else begin
            if (o_adv) begin
                r_ctl2 <= i_ctl;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            for (int l = 0; l < L; l++) begin
                if (i_clr || w_emit) begin
                    r_acc[l] <= '0;
                end else if (w_fire) begin
                    r_acc[l] <= w_sum[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            for (int l = 0; l < L; l++) begin
                r_prod[l] <= i_a[l] * i_b;
            end
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_IMPLY_NEXT(a_emit_sets_valid, i_clk, i_rst_n, w_emit, r_out_valid)
    `ASSERT_IMPLY_NEXT(a_emit_clears_acc, i_clk, i_rst_n, w_emit, (r_acc[0] == '0) && (r_acc[3] == '0))
    `ASSERT_IMPLY(a_hold_only_on_result, i_clk, i_rst_n, !o_adv, r_ctl2.valid && r_ctl2.last_col)

endmodule

// ===== src/int8_gemv_four_row_interleaved.sv =====
// Top level of the int8 matrix-vector unit with four-row interleaved packs.
// Once the final column item of a pack is accepted, its result passes through the vector
// store read register, the product register and the accumulate into the result register.
// Throughput: one item per cycle while the input is not stalled; load and matrix items interleave freely.
// Input stalls only while a finished result waits and the next one is ready to land.
// Reset (synchronous, active low): vector_length 16, pack_count 1, counters and sums zero.
// The vector store is not cleared; entries are defined once written.
`include "assert_macros.svh"

module int8_gemv_four_row_interleaved #(
    parameter int MAX_COLUMNS = i8gemv_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_PACKS   = i8gemv_pkg::MAX_PACKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  i8gemv_pkg::t_in                     i_data,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output i8gemv_pkg::t_out                    o_data,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [i8gemv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i8gemv_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int PW = (MAX_PACKS > 1) ? $clog2(MAX_PACKS) : 1;
    localparam int L  = i8gemv_pkg::LANES;

    // Effective last column and last pack, clamped when the register is written.
    logic [CW-1:0]      r_cols_m1;
    logic [PW-1:0]      r_packs_m1;
    logic [CW-1:0]      n_cols_m1;
    logic [PW-1:0]      n_packs_m1;
    logic [31:0]        w_vl;
    logic [31:0]        w_pc;

    // Running position in the matrix.
    logic [CW-1:0]      r_col;
    logic [PW-1:0]      r_pack;
    logic [31:0]        w_pack32;

    logic               w_adv;
    logic               w_accept;
    logic               w_mat;
    logic               w_load;
    logic [31:0]        w_idx;
    logic               w_last_col;
    logic               w_last_pack;
    logic               w_wr_vl;
    logic               w_wr_pc;
    logic               w_clr;

    // Stage 1: store read in flight, row values held alongside.
    i8gemv_pkg::t_ctl   r_ctl1;
    i8gemv_pkg::t_ctl   n_ctl1;
    logic signed [7:0]  r_a1 [L];
    logic signed [7:0]  w_b;

    assign w_accept = i_valid && w_adv;
    assign o_stall  = !w_adv;
    assign w_mat    = w_accept && (i_data.kind == i8gemv_pkg::KIND_MATRIX);
    assign w_idx    = 32'(i_data.vec_index);
    // Loads beyond the store are dropped.
    assign w_load   = w_accept && (i_data.kind == i8gemv_pkg::KIND_LOAD)
                      && (w_idx < 32'(MAX_COLUMNS));

    assign w_last_col  = (r_col == r_cols_m1);
    assign w_last_pack = (r_pack == r_packs_m1);
    assign w_pack32    = 32'(r_pack);

    // Any register write restarts the matrix; writes past the list do nothing.
    assign w_wr_vl = i_cfg_we && (i_cfg_index == i8gemv_pkg::REG_VECTOR_LENGTH);
    assign w_wr_pc = i_cfg_we && (i_cfg_index == i8gemv_pkg::REG_PACK_COUNT);
    assign w_clr   = w_wr_vl || w_wr_pc;

    // Zero acts as one, values above the limit act as the limit.
    always_comb begin
        w_vl = 32'(i_cfg_data[i8gemv_pkg::VL_W-1:0]);
        w_pc = 32'(i_cfg_data[i8gemv_pkg::PC_W-1:0]);
        if (w_vl == 32'd0) begin
            n_cols_m1 = '0;
        end else if (w_vl > 32'(MAX_COLUMNS)) begin
            n_cols_m1 = CW'(MAX_COLUMNS - 1);
        end else begin
            n_cols_m1 = CW'(w_vl - 32'd1);
        end
        if (w_pc == 32'd0) begin
            n_packs_m1 = '0;
        end else if (w_pc > 32'(MAX_PACKS)) begin
            n_packs_m1 = PW'(MAX_PACKS - 1);
        end else begin
            n_packs_m1 = PW'(w_pc - 32'd1);
        end
    end

    always_comb begin
        n_ctl1.valid      = w_mat;
        n_ctl1.last_col   = w_last_col;
        n_ctl1.pack_index = w_pack32[i8gemv_pkg::PACK_IDX_W-1:0];
        n_ctl1.last_pack  = w_last_pack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_m1  <= CW'(i8gemv_pkg::VL_RESET - 1);
            r_packs_m1 <= '0;
            r_col      <= '0;
            r_pack     <= '0;
            r_ctl1     <= '0;
        end else begin
            if (w_wr_vl) begin
                r_cols_m1 <= n_cols_m1;
            end
            if (w_wr_pc) begin
                r_packs_m1 <= n_packs_m1;
            end
            if (w_adv) begin
                r_ctl1 <= n_ctl1;
            end
            if (w_clr) begin
                r_col  <= '0;
                r_pack <= '0;
            end else if (w_mat) begin
                if (w_last_col) begin
                    r_col  <= '0;
                    r_pack <= w_last_pack ? '0 : r_pack + PW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a1[0] <= i_data.a_row0;
            r_a1[1] <= i_data.a_row1;
            r_a1[2] <= i_data.a_row2;
            r_a1[3] <= i_data.a_row3;
        end
    end

    i8gemv_vstore #(
        .DEPTH  (MAX_COLUMNS),
        .AW     (CW)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_idx[CW-1:0]),
        .i_wdata (i_data.vec_value),
        .i_re    (w_mat),
        .i_raddr (r_col),
        .o_rdata (w_b)
    );

    i8gemv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_clr),
        .i_ctl   (r_ctl1),
        .i_a     (r_a1),
        .i_b     (w_b),
        .i_stall (i_stall),
        .o_adv   (w_adv),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    `ASSERT_ALWAYS(a_col_in_range, i_clk, i_rst_n, r_col <= r_cols_m1)
    `ASSERT_ALWAYS(a_pack_in_range, i_clk, i_rst_n, r_pack <= r_packs_m1)
    `ASSERT_IMPLY_NEXT(a_col_wraps, i_clk, i_rst_n, w_mat && w_last_col, r_col == '0)

endmodule
